### src/xml_node_text_entity_decoder_core_macros.svh
// Assertion macros for the XML element text decoder.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef XML_NODE_TEXT_ENTITY_DECODER_CORE_MACROS_SVH
`define XML_NODE_TEXT_ENTITY_DECODER_CORE_MACROS_SVH

`define XNTD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("xntd: same-cycle check failed");

`define XNTD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("xntd: next-cycle check failed");

`endif

### src/xntd_pkg.sv
// Shared types, codes and entity tables for the XML element text decoder.
// No dependencies.
package xntd_pkg;

    typedef enum logic [3:0] {
        PH_START = 4'b0001,
        PH_TAG   = 4'b0010,
        PH_TEXT  = 4'b0100,
        PH_DONE  = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOTELEM  = 3'd1,
        ST_MISORDER = 3'd2,
        ST_UNTERM   = 3'd3,
        ST_OVERFLOW = 3'd4
    } t_status;

    typedef logic [3:0] t_ent;

    localparam t_ent ENT_NONE = 4'd0;
    localparam t_ent ENT_A1   = 4'd1;
    localparam t_ent ENT_L    = 4'd2;
    localparam t_ent ENT_LT   = 4'd3;
    localparam t_ent ENT_G    = 4'd4;
    localparam t_ent ENT_GT   = 4'd5;
    localparam t_ent ENT_A    = 4'd6;
    localparam t_ent ENT_AM   = 4'd7;
    localparam t_ent ENT_AMP  = 4'd8;

    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_L    = 8'h6C;
    localparam logic [7:0] CH_G    = 8'h67;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_T    = 8'h74;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [7:0] CH_P    = 8'h70;

    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        logic       is_status;
        t_status    status;
        logic       last;
    } t_result;

    function automatic t_ent ent_advance(input t_ent em, input logic [7:0] c);
        t_ent nx;
        nx = ENT_NONE;
        case (em)
            ENT_A1: begin
                if (c == CH_L) nx = ENT_L;
                else if (c == CH_G) nx = ENT_G;
                else if (c == CH_A) nx = ENT_A;
            end
            ENT_L:   if (c == CH_T) nx = ENT_LT;
            ENT_G:   if (c == CH_T) nx = ENT_GT;
            ENT_A:   if (c == CH_M) nx = ENT_AM;
            ENT_AM:  if (c == CH_P) nx = ENT_AMP;
            default: nx = ENT_NONE;
        endcase
        return nx;
    endfunction

    function automatic logic ent_complete(input t_ent em, input logic [7:0] c);
        return (c == CH_SEMI) && ((em == ENT_LT) || (em == ENT_GT) || (em == ENT_AMP));
    endfunction

    function automatic logic [7:0] ent_char(input t_ent em);
        logic [7:0] b;
        case (em)
            ENT_LT:  b = CH_LT;
            ENT_GT:  b = CH_GT;
            default: b = CH_AMP;
        endcase
        return b;
    endfunction

    function automatic logic [2:0] prefix_len(input t_ent em);
        logic [2:0] n;
        case (em) inside
            ENT_A1:                         n = 3'd1;
            ENT_L, ENT_G, ENT_A:            n = 3'd2;
            ENT_LT, ENT_GT, ENT_AM:         n = 3'd3;
            ENT_AMP:                        n = 3'd4;
            default:                        n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] prefix_byte(input t_ent em, input logic [2:0] k);
        logic [7:0] b;
        b = CH_AMP;
        case (k)
            3'd1: begin
                case (em) inside
                    ENT_L, ENT_LT: b = CH_L;
                    ENT_G, ENT_GT: b = CH_G;
                    default:       b = CH_A;
                endcase
            end
            3'd2:    b = ((em == ENT_AM) || (em == ENT_AMP)) ? CH_M : CH_T;
            3'd3:    b = CH_P;
            default: b = CH_AMP;
        endcase
        return b;
    endfunction

endpackage

### src/xml_node_text_entity_decoder_core.sv
// Top level of the XML element text decoder: input register, engine, output register.
// Depends on xntd_pkg, xntd_in_reg, xntd_engine, xntd_out_reg and the macros header.
//
// Takes one string byte per cycle unless stalled and delivers one result per cycle
// while i_out_stall is low. A byte goes from the input register via the engine to the
// output register; a failed partial entity is flushed raw one byte per cycle while the
// output is free and the byte that broke it waits. The output register stalls the engine
// only while its result is not taken. The buffer_size register is written through its own
// channel, which is always ready, and should be written only between strings.
`include "xml_node_text_entity_decoder_core_macros.svh"

module xml_node_text_entity_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_is_status,
    output logic [2:0]  o_status,
    output logic        o_last
);

    logic [15:0]       r_buffer_size;
    logic              consume;
    logic              in_valid_q;
    logic [7:0]        in_byte_q;
    logic              in_last_q;
    logic              out_free;
    xntd_pkg::t_result res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= 16'd2048;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_buffer_size <= i_cfg_data;
        end
    end

    xntd_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .i_consume  (consume),
        .o_valid    (in_valid_q),
        .o_byte     (in_byte_q),
        .o_last     (in_last_q)
    );

    xntd_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (in_valid_q),
        .i_byte        (in_byte_q),
        .i_last        (in_last_q),
        .i_buffer_size (r_buffer_size),
        .i_out_free    (out_free),
        .o_consume     (consume),
        .o_res         (res)
    );

    xntd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (in_valid_q && res.valid),
        .i_res       (res),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_is_status (o_is_status),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    // An input held back while the output side is free means a flushed byte is on its way.
    `XNTD_ASSERT_NEXT(a_flush_gives_result, o_in_stall && !i_out_stall, o_out_valid)
    `XNTD_ASSERT_IMPL(a_status_fields, o_out_valid && o_is_status, o_last && (o_out_byte == 8'd0))
    `XNTD_ASSERT_IMPL(a_data_fields, o_out_valid && !o_is_status, !o_last && (o_status == 3'd0))

endmodule

### src/xntd_in_reg.sv
// Input register of the XML element text decoder.
// Holds one accepted byte until the engine has finished with it; no dependencies.
module xntd_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    input  logic       i_consume,
    output logic       o_valid,
    output logic [7:0] o_byte,
    output logic       o_last
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;

    assign o_in_stall = r_valid && !i_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_byte <= i_in_byte;
            r_last <= i_in_last;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule

### src/xntd_engine.sv
// Decoding engine: string state, entity matcher and flush counter.
// Produces at most one result per cycle; depends on xntd_pkg.
module xntd_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  logic [15:0]      i_buffer_size,
    input  logic             i_out_free,
    output logic             o_consume,
    output xntd_pkg::t_result o_res
);

    xntd_pkg::t_phase  r_phase, n_phase;
    xntd_pkg::t_ent    r_em, n_em;
    logic [15:0]       r_cnt, n_cnt;
    logic [2:0]        r_sub, n_sub;

    xntd_pkg::t_ent    nx;
    logic              ent_done;
    logic              item_done;
    logic              do_emit;
    logic              do_fin;
    logic [7:0]        emit_b;
    xntd_pkg::t_status fin_code;
    logic              ovf;
    logic              fire;

    assign nx       = xntd_pkg::ent_advance(r_em, i_byte);
    assign ent_done = xntd_pkg::ent_complete(r_em, i_byte);
    assign ovf      = (i_buffer_size == 16'd0) || (r_cnt >= (i_buffer_size - 16'd1));
    assign fire     = i_valid && i_out_free;

    always_comb begin
        n_phase   = r_phase;
        n_em      = r_em;
        n_cnt     = r_cnt;
        n_sub     = 3'd0;
        item_done = 1'b1;
        do_emit   = 1'b0;
        do_fin    = 1'b0;
        emit_b    = i_byte;
        fin_code  = xntd_pkg::ST_OK;
        o_res     = '0;

        unique case (r_phase)
            xntd_pkg::PH_START: begin
                n_cnt = 16'd0;
                n_em  = xntd_pkg::ENT_NONE;
                if (i_buffer_size == 16'd0) begin
                    do_fin   = 1'b1;
                    fin_code = xntd_pkg::ST_OVERFLOW;
                end else if (i_byte != xntd_pkg::CH_LT) begin
                    do_fin   = 1'b1;
                    fin_code = xntd_pkg::ST_NOTELEM;
                end else if (i_last) begin
                    do_fin   = 1'b1;
                    fin_code = xntd_pkg::ST_UNTERM;
                end else begin
                    n_phase = xntd_pkg::PH_TAG;
                end
            end
            xntd_pkg::PH_TAG: begin
                if (i_byte == xntd_pkg::CH_LT) begin
                    do_fin   = 1'b1;
                    fin_code = xntd_pkg::ST_MISORDER;
                end else if (i_last) begin
                    do_fin   = 1'b1;
                    fin_code = xntd_pkg::ST_UNTERM;
                end else if (i_byte == xntd_pkg::CH_GT) begin
                    n_phase = xntd_pkg::PH_TEXT;
                end
            end
            xntd_pkg::PH_TEXT: begin
                if (i_byte != xntd_pkg::CH_LT && i_last) begin
                    do_fin   = 1'b1;
                    fin_code = xntd_pkg::ST_UNTERM;
                end else if (r_em != xntd_pkg::ENT_NONE && nx != xntd_pkg::ENT_NONE) begin
                    n_em = nx;
                end else if (r_em != xntd_pkg::ENT_NONE && ent_done) begin
                    n_em    = xntd_pkg::ENT_NONE;
                    do_emit = 1'b1;
                    emit_b  = xntd_pkg::ent_char(r_em);
                end else if (r_sub < xntd_pkg::prefix_len(r_em)) begin
                    do_emit   = 1'b1;
                    emit_b    = xntd_pkg::prefix_byte(r_em, r_sub);
                    item_done = 1'b0;
                    n_sub     = r_sub + 3'd1;
                end else begin
                    n_em = xntd_pkg::ENT_NONE;
                    if (i_byte == xntd_pkg::CH_LT) begin
                        do_fin   = 1'b1;
                        fin_code = xntd_pkg::ST_OK;
                    end else if (i_byte == xntd_pkg::CH_AMP) begin
                        n_em = xntd_pkg::ENT_A1;
                    end else begin
                        do_emit = 1'b1;
                    end
                end
            end
            xntd_pkg::PH_DONE: begin
                if (i_last) n_phase = xntd_pkg::PH_START;
            end
            default: begin
                n_phase = xntd_pkg::PH_START;
            end
        endcase

        if (do_emit) begin
            if (ovf) begin
                do_fin    = 1'b1;
                fin_code  = xntd_pkg::ST_OVERFLOW;
                item_done = 1'b1;
                n_sub     = 3'd0;
            end else begin
                o_res.valid    = 1'b1;
                o_res.out_byte = emit_b;
                n_cnt          = r_cnt + 16'd1;
            end
        end

        if (do_fin) begin
            o_res.valid     = 1'b1;
            o_res.out_byte  = 8'd0;
            o_res.is_status = 1'b1;
            o_res.status    = fin_code;
            o_res.last      = 1'b1;
            n_em            = xntd_pkg::ENT_NONE;
            n_phase         = i_last ? xntd_pkg::PH_START : xntd_pkg::PH_DONE;
        end
    end

    assign o_consume = fire && item_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= xntd_pkg::PH_START;
            r_em    <= xntd_pkg::ENT_NONE;
            r_cnt   <= 16'd0;
            r_sub   <= 3'd0;
        end else if (fire) begin
            r_phase <= n_phase;
            r_em    <= n_em;
            r_cnt   <= n_cnt;
            r_sub   <= n_sub;
        end
    end

endmodule

### src/xntd_out_reg.sv
// Output register of the XML element text decoder.
// Holds one result until the consumer takes it; depends on xntd_pkg.
module xntd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  xntd_pkg::t_result i_res,
    output logic              o_free,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_is_status,
    output logic [2:0]        o_status,
    output logic              o_last
);

    logic              r_valid;
    xntd_pkg::t_result r_res;

    assign o_free = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_byte  = r_res.out_byte;
    assign o_is_status = r_res.is_status;
    assign o_status    = r_res.status;
    assign o_last      = r_res.last;

endmodule

### dv/xntd_text_checker.sv
// Checker for the XML element text decoder: watches the register, input and output channels.
// Predicts the decoded text and status of each string and compares every result transfer.
// Depends on xntd_pkg for the phase, status, entity codes and character constants.
`timescale 1ns / 100ps

module xntd_text_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_out_byte,
    input  logic        i_is_status,
    input  logic [2:0]  i_status,
    input  logic        i_last,
    output int          o_fails,
    output int          o_pending,
    output int          o_strings,
    output int          o_text_bytes,
    output logic [4:0]  o_codes_seen
);

    typedef struct packed {
        logic              [7:0] data;
        logic              is_st;
        xntd_pkg::t_status code;
        logic              fin;
    } t_text_item;

    t_text_item       expected_q[$];
    logic [15:0]      buf_size;
    xntd_pkg::t_phase ph;
    xntd_pkg::t_ent   ent;
    logic [15:0]      text_len;
    int               fail_cnt = 0;
    int               string_cnt = 0;
    int               byte_cnt = 0;
    logic [4:0]       codes = 5'b0;

    function automatic xntd_pkg::t_ent next_prefix(input xntd_pkg::t_ent e,
                                                   input logic [7:0] c);
        case (e)
            xntd_pkg::ENT_A1:  return (c == xntd_pkg::CH_L) ? xntd_pkg::ENT_L :
                                      (c == xntd_pkg::CH_G) ? xntd_pkg::ENT_G :
                                      (c == xntd_pkg::CH_A) ? xntd_pkg::ENT_A :
                                      xntd_pkg::ENT_NONE;
            xntd_pkg::ENT_L:   return (c == xntd_pkg::CH_T) ? xntd_pkg::ENT_LT :
                                      xntd_pkg::ENT_NONE;
            xntd_pkg::ENT_G:   return (c == xntd_pkg::CH_T) ? xntd_pkg::ENT_GT :
                                      xntd_pkg::ENT_NONE;
            xntd_pkg::ENT_A:   return (c == xntd_pkg::CH_M) ? xntd_pkg::ENT_AM :
                                      xntd_pkg::ENT_NONE;
            xntd_pkg::ENT_AM:  return (c == xntd_pkg::CH_P) ? xntd_pkg::ENT_AMP :
                                      xntd_pkg::ENT_NONE;
            default:           return xntd_pkg::ENT_NONE;
        endcase
    endfunction

    // Raw spelling of a partial entity, first character in the top byte.
    function automatic logic [31:0] prefix_text(input xntd_pkg::t_ent e);
        case (e)
            xntd_pkg::ENT_A1:  return {xntd_pkg::CH_AMP, 24'h0};
            xntd_pkg::ENT_L:   return {xntd_pkg::CH_AMP, xntd_pkg::CH_L, 16'h0};
            xntd_pkg::ENT_LT:  return {xntd_pkg::CH_AMP, xntd_pkg::CH_L, xntd_pkg::CH_T, 8'h0};
            xntd_pkg::ENT_G:   return {xntd_pkg::CH_AMP, xntd_pkg::CH_G, 16'h0};
            xntd_pkg::ENT_GT:  return {xntd_pkg::CH_AMP, xntd_pkg::CH_G, xntd_pkg::CH_T, 8'h0};
            xntd_pkg::ENT_A:   return {xntd_pkg::CH_AMP, xntd_pkg::CH_A, 16'h0};
            xntd_pkg::ENT_AM:  return {xntd_pkg::CH_AMP, xntd_pkg::CH_A, xntd_pkg::CH_M, 8'h0};
            xntd_pkg::ENT_AMP: return {xntd_pkg::CH_AMP, xntd_pkg::CH_A, xntd_pkg::CH_M,
                                       xntd_pkg::CH_P};
            default:           return 32'h0;
        endcase
    endfunction

    function automatic int prefix_count(input xntd_pkg::t_ent e);
        case (e) inside
            xntd_pkg::ENT_A1:                                     return 1;
            xntd_pkg::ENT_L, xntd_pkg::ENT_G, xntd_pkg::ENT_A:    return 2;
            xntd_pkg::ENT_LT, xntd_pkg::ENT_GT, xntd_pkg::ENT_AM: return 3;
            xntd_pkg::ENT_AMP:                                    return 4;
            default:                                              return 0;
        endcase
    endfunction

    task automatic end_string(input xntd_pkg::t_status code, input logic fin);
        expected_q.push_back('{8'h00, 1'b1, code, 1'b1});
        ent = xntd_pkg::ENT_NONE;
        ph = fin ? xntd_pkg::PH_START : xntd_pkg::PH_DONE;
    endtask

    task automatic put_text(input logic [7:0] b, input logic fin, output bit ok);
        if (buf_size == 16'd0 || {16'h0, text_len} >= {16'h0, buf_size} - 32'd1) begin
            end_string(xntd_pkg::ST_OVERFLOW, fin);
            ok = 1'b0;
        end else begin
            expected_q.push_back('{b, 1'b0, xntd_pkg::ST_OK, 1'b0});
            text_len = text_len + 16'd1;
            ok = 1'b1;
        end
    endtask

    task automatic predict_byte(input logic [7:0] c, input logic fin);
        xntd_pkg::t_ent nx;
        bit             ok;
        logic [31:0]    spelled;
        logic [7:0]     decoded;
        int             n;
        int             k;
        case (ph)
            xntd_pkg::PH_START: begin
                text_len = 16'd0;
                ent = xntd_pkg::ENT_NONE;
                if (buf_size == 16'd0) end_string(xntd_pkg::ST_OVERFLOW, fin);
                else if (c != xntd_pkg::CH_LT) end_string(xntd_pkg::ST_NOTELEM, fin);
                else if (fin) end_string(xntd_pkg::ST_UNTERM, fin);
                else ph = xntd_pkg::PH_TAG;
            end
            xntd_pkg::PH_TAG: begin
                if (c == xntd_pkg::CH_LT) end_string(xntd_pkg::ST_MISORDER, fin);
                else if (fin) end_string(xntd_pkg::ST_UNTERM, fin);
                else if (c == xntd_pkg::CH_GT) ph = xntd_pkg::PH_TEXT;
            end
            xntd_pkg::PH_TEXT: begin
                if (c != xntd_pkg::CH_LT && fin) begin
                    end_string(xntd_pkg::ST_UNTERM, fin);
                    return;
                end
                if (ent != xntd_pkg::ENT_NONE) begin
                    nx = next_prefix(ent, c);
                    if (nx != xntd_pkg::ENT_NONE) begin
                        ent = nx;
                        return;
                    end
                    if (c == xntd_pkg::CH_SEMI && (ent == xntd_pkg::ENT_LT ||
                        ent == xntd_pkg::ENT_GT || ent == xntd_pkg::ENT_AMP)) begin
                        decoded = (ent == xntd_pkg::ENT_LT) ? xntd_pkg::CH_LT :
                                  (ent == xntd_pkg::ENT_GT) ? xntd_pkg::CH_GT :
                                  xntd_pkg::CH_AMP;
                        ent = xntd_pkg::ENT_NONE;
                        put_text(decoded, fin, ok);
                        return;
                    end
                    spelled = prefix_text(ent);
                    n = prefix_count(ent);
                    ent = xntd_pkg::ENT_NONE;
                    for (k = 0; k < n; k++) begin
                        put_text(spelled[31 - 8 * k -: 8], fin, ok);
                        if (!ok) return;
                    end
                end
                if (c == xntd_pkg::CH_LT) end_string(xntd_pkg::ST_OK, fin);
                else if (c == xntd_pkg::CH_AMP) ent = xntd_pkg::ENT_A1;
                else put_text(c, fin, ok);
            end
            default: begin
                if (fin) ph = xntd_pkg::PH_START;
            end
        endcase
    endtask

    task automatic compare_result();
        t_text_item e;
        if (expected_q.size() == 0) begin
            fail_cnt++;
            if (fail_cnt <= 10)
                $display("%0t: unexpected result: byte %02h flag %0b code %0d last %0b",
                         $time, i_out_byte, i_is_status, i_status, i_last);
        end else begin
            e = expected_q.pop_front();
            if (i_out_byte !== e.data || i_is_status !== e.is_st || i_status !== e.code ||
                i_last !== e.fin) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("%0t: mismatch: expected byte %02h flag %0b code %0d last %0b, %s",
                             $time, e.data, e.is_st, e.code, e.fin, $sformatf(
                             "got byte %02h flag %0b code %0d last %0b",
                             i_out_byte, i_is_status, i_status, i_last));
            end
            if (e.is_st) begin
                string_cnt++;
                codes[e.code] = 1'b1;
            end else begin
                byte_cnt++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            buf_size = 16'd2048;
            ph = xntd_pkg::PH_START;
            ent = xntd_pkg::ENT_NONE;
            text_len = 16'd0;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) buf_size = i_cfg_data;
            if (i_in_valid && !i_in_stall) predict_byte(i_in_byte, i_in_last);
            if (i_out_valid && !i_out_stall) compare_result();
        end
        o_fails <= fail_cnt;
        o_pending <= expected_q.size();
        o_strings <= string_cnt;
        o_text_bytes <= byte_cnt;
        o_codes_seen <= codes;
    end

endmodule

### dv/tb_top.sv
// Top of the XML element text decoder testbench: clock, reset, stimulus and verdict.
// Drives directed and random strings through several buffer sizes with random idling.
// Depends on xntd_pkg, the decoder top level and xntd_text_checker.
`timescale 1ns / 100ps

module tb_top;

    typedef enum int {
        PACE_FLAT,
        PACE_BUSY,
        PACE_SPARSE
    } t_pace;

    localparam int HOLD_CYCLES = 200;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_in_byte;
    logic        i_in_last;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_out_byte;
    logic        o_is_status;
    logic [2:0]  o_status;
    logic        o_last;

    int          fails;
    int          pending;
    int          strings_done;
    int          text_bytes;
    logic [4:0]  codes_seen;

    logic [8:0]  str_q[$];
    int          budget;
    bit          hold_req = 1'b0;
    bit          tx_burst = 1'b0;
    t_pace       tx_mode = PACE_BUSY;
    t_pace       rx_mode = PACE_FLAT;
    int          tx_count = 0;
    string       entities[3] = '{"&lt;", "&gt;", "&amp;"};
    string       prefixes[8] = '{"&", "&l", "&lt", "&g", "&gt", "&a", "&am", "&amp"};

    always #5 i_clk = ~i_clk;

    xml_node_text_entity_decoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_is_status (o_is_status),
        .o_status    (o_status),
        .o_last      (o_last)
    );

    xntd_text_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_byte   (o_out_byte),
        .i_is_status  (o_is_status),
        .i_status     (o_status),
        .i_last       (o_last),
        .o_fails      (fails),
        .o_pending    (pending),
        .o_strings    (strings_done),
        .o_text_bytes (text_bytes),
        .o_codes_seen (codes_seen)
    );

    function automatic int draw_wait(input t_pace mode);
        if (mode == PACE_FLAT) return 0;
        if (mode == PACE_BUSY) return $urandom_range(0, 16);
        return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
    endfunction

    function automatic logic [7:0] any_but(input logic [7:0] x1, input logic [7:0] x2);
        logic [7:0] b;
        do b = 8'($urandom); while (b == x1 || b == x2);
        return b;
    endfunction

    task automatic add(input logic [7:0] b, input logic fin);
        str_q.push_back({fin, b});
    endtask

    task automatic add_chars(input string s);
        for (int i = 0; i < s.len(); i++) add(s[i], 1'b0);
    endtask

    task automatic add_tag();
        repeat ($urandom_range(0, 4)) add(any_but(xntd_pkg::CH_LT, xntd_pkg::CH_GT), 1'b0);
    endtask

    task automatic add_text();
        int k;
        repeat ($urandom_range(0, 8)) begin
            k = $urandom_range(0, 9);
            if (k <= 4) add(any_but(xntd_pkg::CH_LT, xntd_pkg::CH_LT), 1'b0);
            else if (k <= 6) add_chars(entities[$urandom_range(0, 2)]);
            else add_chars(prefixes[$urandom_range(0, 7)]);
        end
    endtask

    // Bytes after a status are dropped by the block until the one marked last.
    task automatic add_tail(output int cnt);
        cnt = $urandom_range(0, 3);
        repeat (cnt) add(8'($urandom), 1'b0);
        add(8'($urandom), 1'b1);
        cnt++;
    endtask

    task automatic send_item(input logic [7:0] b, input logic fin);
        int w;
        w = tx_burst ? 0 : draw_wait(tx_mode);
        tx_count++;
        if (tx_count % 24 == 0) tx_mode = t_pace'($urandom_range(0, 2));
        if (w > 0) begin
            i_in_valid <= 1'b0;
            repeat (w) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte <= b;
        i_in_last <= fin;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_string();
        foreach (str_q[i]) send_item(str_q[i][7:0], str_q[i][8]);
        str_q.delete();
    endtask

    task automatic random_string();
        int         kind;
        int         extra;
        int         n;
        logic [7:0] b;
        kind = $urandom_range(0, 9);
        extra = 0;
        if (kind <= 5) begin
            add(xntd_pkg::CH_LT, 1'b0);
            add_tag();
            add(xntd_pkg::CH_GT, 1'b0);
            add_text();
            if ($urandom_range(0, 2) == 0) begin
                add(xntd_pkg::CH_LT, 1'b1);
            end else begin
                add(xntd_pkg::CH_LT, 1'b0);
                add_tail(extra);
            end
        end else if (kind == 6) begin
            n = $urandom_range(1, 6);
            repeat (n - 1) add(8'($urandom), 1'b0);
            add(8'($urandom), 1'b1);
        end else if (kind == 7) begin
            b = any_but(xntd_pkg::CH_LT, xntd_pkg::CH_LT);
            if ($urandom_range(0, 1) == 0) begin
                add(b, 1'b1);
            end else begin
                add(b, 1'b0);
                add_tail(extra);
            end
        end else if (kind == 8) begin
            add(xntd_pkg::CH_LT, 1'b0);
            add_tag();
            if ($urandom_range(0, 1) == 0) begin
                add(xntd_pkg::CH_LT, 1'b1);
            end else begin
                add(xntd_pkg::CH_LT, 1'b0);
                add_tail(extra);
            end
        end else begin
            add(xntd_pkg::CH_LT, 1'b0);
            add_tag();
            if ($urandom_range(0, 1) == 0) begin
                add(any_but(xntd_pkg::CH_LT, xntd_pkg::CH_LT), 1'b1);
            end else begin
                add(xntd_pkg::CH_GT, 1'b0);
                add_text();
                add(any_but(xntd_pkg::CH_LT, xntd_pkg::CH_LT), 1'b1);
            end
        end
        budget -= str_q.size() - extra;
        send_string();
    endtask

    task automatic cfg_write(input logic [15:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin : rx_side
        int w;
        int n_rx;
        n_rx = 0;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            w = draw_wait(rx_mode);
            n_rx++;
            if (n_rx % 24 == 0) rx_mode = t_pace'($urandom_range(0, 2));
            if (w > 0) begin
                i_out_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin : stimulus
        logic [15:0] sizes[7];
        int          quota[7];
        logic [15:0] rnd_size;
        int          p;
        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data <= 16'h0;
        i_in_valid <= 1'b0;
        i_in_byte <= 8'h0;
        i_in_last <= 1'b0;
        rnd_size = 16'($urandom_range(3, 40));
        sizes = '{16'd0, 16'd1, 16'd2, 16'd5, 16'hFFFF, rnd_size, 16'd2048};
        quota = '{15, 18, 18, 32, 40, 40, 32};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        cfg_write(16'd2048);

        add_chars("<>&lt;&gt;&amp;");
        add(xntd_pkg::CH_LT, 1'b1);
        add(8'hFF, 1'b1);
        add(xntd_pkg::CH_LT, 1'b1);
        add(xntd_pkg::CH_LT, 1'b0);
        add(xntd_pkg::CH_LT, 1'b1);
        add_chars("<>&a");
        add(xntd_pkg::CH_LT, 1'b1);
        send_string();
        i_in_valid <= 1'b0;
        drain();

        for (p = 0; p < 7; p++) begin
            cfg_write(sizes[p]);
            if (p == 6) begin
                tx_burst = 1'b1;
                hold_req = 1'b1;
                add_chars("<p>");
                repeat (32) add(any_but(xntd_pkg::CH_LT, xntd_pkg::CH_LT), 1'b0);
                add(xntd_pkg::CH_LT, 1'b1);
                send_string();
                tx_burst = 1'b0;
            end
            budget = quota[p];
            while (budget > 0) random_string();
            i_in_valid <= 1'b0;
            drain();
        end

        $display("Covered %0d strings with %0d decoded text bytes; status codes seen %b.",
                 strings_done, text_bytes, codes_seen);
        $display("Buffer sizes used: 2048, 0, 1, 2, 5, 65535 and %0d.", rnd_size);
        if (fails == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
